/* hw/rtl/tst_pkg.sv */
// ----------------------------------------------------------------------------
// tst_pkg
// Shared constants, types and helpers for the TCP segment tracker.
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam int SEQ_W    = 32;
    localparam int ACK_W    = 32;
    localparam int HDR_W    = 4;
    localparam int LEN_W    = 16;
    localparam int FLAG_W   = 8;
    localparam int WIN_W    = 16;
    localparam int STAMP_W  = 32;
    // header length in bytes: words times four
    localparam int HBYTES_W = HDR_W + 2;
    // payload length plus SYN plus FIN
    localparam int SEQLEN_W = LEN_W + 1;

    // bit positions in the TCP flag byte
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 4;

    // classification of one request
    typedef struct packed {
        logic bad_segment;
        logic has_payload;
        logic retransmitted;
        logic window_grew;
        logic ack_advanced;
        logic duplicate_ack;
        logic stale_ack;
    } seg_class_t;

    // a lies before b in wrap-around sequence space
    function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                        input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] diff;
        diff = a - b;
        return diff[SEQ_W-1];
    endfunction

endpackage

/* hw/rtl/tcp_segment_tracker_core.sv */
// ----------------------------------------------------------------------------
// tcp_segment_tracker_core
// Classifies the segment headers of one direction of one TCP connection and
// keeps next-send, next-receive, window, newest timestamp and sticky FIN.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | in_valid, in_stall, header ports | to core
//  out      | out_valid, out_stall, class/seq  | from core
//
//  one request per cycle sustained while out_stall is low
//  the input register feeds one compare/update pass that commits the
//  connection state in the same edge that loads the result register
//  reset clears all connection state to zero, connection not yet valid
//  a stalled result holds the pass; in_stall rises only while both the
//  input and the result register are full and out_stall is high
// ----------------------------------------------------------------------------
module tcp_segment_tracker_core
    import tst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SEQ_W-1:0]    seq_number,
    input  logic [ACK_W-1:0]    ack_number,
    input  logic [HDR_W-1:0]    header_words,
    input  logic [LEN_W-1:0]    segment_bytes,
    input  logic [FLAG_W-1:0]   flag_byte,
    input  logic [WIN_W-1:0]    window_size,
    input  logic                stamp_present,
    input  logic [STAMP_W-1:0]  stamp_value,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                bad_segment,
    output logic                has_payload,
    output logic                retransmitted,
    output logic                window_grew,
    output logic                ack_advanced,
    output logic                duplicate_ack,
    output logic                stale_ack,
    output logic [SEQ_W-1:0]    end_sequence,
    output logic [SEQ_W-1:0]    next_send_out,
    output logic [ACK_W-1:0]    next_receive_out
);

    // input register
    logic                s1_valid_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic [ACK_W-1:0]    ack_reg;
    logic [HDR_W-1:0]    hwords_reg;
    logic [LEN_W-1:0]    segb_reg;
    logic [FLAG_W-1:0]   fb_reg;
    logic [WIN_W-1:0]    win_reg;
    logic                stamp_p_reg;
    logic [STAMP_W-1:0]  stamp_reg;

    // connection state
    logic [SEQ_W-1:0]    next_send_reg, next_send_next;
    logic [ACK_W-1:0]    next_receive_reg, next_receive_next;
    logic [WIN_W-1:0]    last_window_reg, last_window_next;
    logic [STAMP_W-1:0]  newest_stamp_reg, newest_stamp_next;
    logic                conn_valid_reg, conn_valid_next;
    logic                fin_seen_reg, fin_seen_next;
    logic                stamp_valid_reg, stamp_valid_next;

    // result register
    logic                out_valid_reg;
    seg_class_t          class_reg, class_next;
    logic [SEQ_W-1:0]    endseq_reg, endseq_next;

    logic                out_load;
    logic                s1_move;
    logic                in_load;

    // handshake
    assign out_load = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign in_load  = in_valid && !in_stall;

    // single pass over the registered header
    logic [HBYTES_W-1:0] hbytes;
    logic [LEN_W-1:0]    plen;
    logic [SEQLEN_W-1:0] seqlen;
    logic                seg_fin, seg_syn, seg_rst, seg_ack;
    logic                seqlen_zero;
    logic                bad;
    logic [SEQ_W-1:0]    endseq;
    logic                classify;
    logic                retx, ackup, pure_ack, dup, stale, wgrow;

    always_comb
    begin
        hbytes      = {hwords_reg, 2'b00};
        seg_fin     = fb_reg[FLAG_FIN];
        seg_syn     = fb_reg[FLAG_SYN];
        seg_rst     = fb_reg[FLAG_RST];
        seg_ack     = fb_reg[FLAG_ACK];
        bad         = (segb_reg < {{(LEN_W-HBYTES_W){1'b0}}, hbytes}) ||
                      (seg_fin && seg_syn);
        plen        = segb_reg - {{(LEN_W-HBYTES_W){1'b0}}, hbytes};
        seqlen      = {1'b0, plen} + {{(SEQLEN_W-1){1'b0}}, seg_fin}
                                   + {{(SEQLEN_W-1){1'b0}}, seg_syn};
        seqlen_zero = (seqlen == '0);
        endseq      = seq_reg + {{(SEQ_W-SEQLEN_W){1'b0}}, seqlen};
        classify    = !seg_rst && conn_valid_reg;

        retx     = classify && !seqlen_zero &&
                   (seq_before(endseq, next_send_reg) ||
                    ((endseq == next_send_reg) && seq_before(seq_reg, next_send_reg)));
        ackup    = classify && seg_ack && seq_before(next_receive_reg, ack_reg);
        pure_ack = classify && !ackup && seg_ack && seqlen_zero;
        dup      = pure_ack && (ack_reg == next_receive_reg);
        stale    = pure_ack && (ack_reg != next_receive_reg);
        wgrow    = classify && (win_reg > last_window_reg) && !stale;

        // state defaults: unchanged
        next_send_next    = next_send_reg;
        next_receive_next = next_receive_reg;
        last_window_next  = last_window_reg;
        newest_stamp_next = newest_stamp_reg;
        conn_valid_next   = conn_valid_reg;
        fin_seen_next     = fin_seen_reg;
        stamp_valid_next  = stamp_valid_reg;

        class_next  = '0;
        endseq_next = seq_reg;

        if (bad)
        begin
            class_next.bad_segment = 1'b1;
        end
        else
        begin
            class_next.has_payload   = (plen != '0);
            class_next.retransmitted = retx;
            class_next.window_grew   = wgrow;
            class_next.ack_advanced  = ackup;
            class_next.duplicate_ack = dup;
            class_next.stale_ack     = stale;
            endseq_next              = endseq;

            // first segment takes the ack even without ACK
            if (ackup || !conn_valid_reg)
                next_receive_next = ack_reg;
            if (!stale)
                last_window_next = win_reg;
            if (stamp_p_reg)
            begin
                if (!stamp_valid_reg || seq_before(newest_stamp_reg, stamp_reg))
                    newest_stamp_next = stamp_reg;
                stamp_valid_next = 1'b1;
            end
            if (!retx)
            begin
                conn_valid_next = 1'b1;
                // fin stays sticky across zero-length segments
                fin_seen_next   = seg_fin || (fin_seen_reg && seqlen_zero);
                if (!seqlen_zero)
                    next_send_next = endseq;
            end
        end
    end

    // control and connection state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            next_send_reg    <= '0;
            next_receive_reg <= '0;
            last_window_reg  <= '0;
            newest_stamp_reg <= '0;
            conn_valid_reg   <= 1'b0;
            fin_seen_reg     <= 1'b0;
            stamp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_load)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= s1_valid_reg;

            if (s1_move)
            begin
                next_send_reg    <= next_send_next;
                next_receive_reg <= next_receive_next;
                last_window_reg  <= last_window_next;
                newest_stamp_reg <= newest_stamp_next;
                conn_valid_reg   <= conn_valid_next;
                fin_seen_reg     <= fin_seen_next;
                stamp_valid_reg  <= stamp_valid_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            seq_reg     <= seq_number;
            ack_reg     <= ack_number;
            hwords_reg  <= header_words;
            segb_reg    <= segment_bytes;
            fb_reg      <= flag_byte;
            win_reg     <= window_size;
            stamp_p_reg <= stamp_present;
            stamp_reg   <= stamp_value;
        end
        if (s1_move)
        begin
            class_reg  <= class_next;
            endseq_reg <= endseq_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign bad_segment      = class_reg.bad_segment;
    assign has_payload      = class_reg.has_payload;
    assign retransmitted    = class_reg.retransmitted;
    assign window_grew      = class_reg.window_grew;
    assign ack_advanced     = class_reg.ack_advanced;
    assign duplicate_ack    = class_reg.duplicate_ack;
    assign stale_ack        = class_reg.stale_ack;
    assign end_sequence     = endseq_reg;
    assign next_send_out    = next_send_reg;
    assign next_receive_out = next_receive_reg;

`ifndef ASSERT_OFF
    // malformed request carries no other classification
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_segment |->
            !(has_payload || retransmitted || window_grew || ack_advanced ||
              duplicate_ack || stale_ack))
        else $error("bad segment with classification bits set");

    // ack classes exclude each other
    a_ack_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({ack_advanced, duplicate_ack, stale_ack}))
        else $error("more than one ack class");

    // stale ack never reports a window update
    a_stale_win: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stale_ack |-> !window_grew)
        else $error("stale ack with window growth");

    // a retransmission leaves next-send alone
    a_retx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && retx |=> $stable(next_send_reg))
        else $error("next-send moved on retransmission");

    // stall only with a full input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipe");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the TCP segment tracker. Segment headers go in through the
// valid/stall channel, and a behavioral tracker with its own copy of the
// connection state predicts each verdict. Every result is checked field by
// field in order. Directed segments cover malformed headers, connection open,
// wrap-around, each classification, FIN and RST. A random phase follows, and
// a long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
    import tst_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 450;

    // bits of the stored connection flags
    localparam int CONN_SYN   = 0;
    localparam int CONN_FIN   = 1;
    localparam int CONN_ACK   = 2;
    localparam int CONN_VALID = 3;
    localparam int CONN_STAMP = 4;

    localparam logic [FLAG_W-1:0] F_FIN = FLAG_W'(1 << FLAG_FIN);
    localparam logic [FLAG_W-1:0] F_SYN = FLAG_W'(1 << FLAG_SYN);
    localparam logic [FLAG_W-1:0] F_RST = FLAG_W'(1 << FLAG_RST);
    localparam logic [FLAG_W-1:0] F_ACK = FLAG_W'(1 << FLAG_ACK);
    localparam logic [FLAG_W-1:0] F_PSH = 8'h08;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [ACK_W-1:0]   ack;
        logic [HDR_W-1:0]   hwords;
        logic [LEN_W-1:0]   seg_len;
        logic [FLAG_W-1:0]  flags;
        logic [WIN_W-1:0]   win;
        logic               stamp_on;
        logic [STAMP_W-1:0] stamp;
    } seg_hdr_t;

    typedef struct packed {
        seg_class_t         cls;
        logic [SEQ_W-1:0]   end_seq;
        logic [SEQ_W-1:0]   nxt_send;
        logic [ACK_W-1:0]   nxt_recv;
    } seg_verdict_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SEQ_W-1:0]    seq_number;
    logic [ACK_W-1:0]    ack_number;
    logic [HDR_W-1:0]    header_words;
    logic [LEN_W-1:0]    segment_bytes;
    logic [FLAG_W-1:0]   flag_byte;
    logic [WIN_W-1:0]    window_size;
    logic                stamp_present;
    logic [STAMP_W-1:0]  stamp_value;
    logic                out_valid;
    logic                out_stall;
    logic                bad_segment;
    logic                has_payload;
    logic                retransmitted;
    logic                window_grew;
    logic                ack_advanced;
    logic                duplicate_ack;
    logic                stale_ack;
    logic [SEQ_W-1:0]    end_sequence;
    logic [SEQ_W-1:0]    next_send_out;
    logic [ACK_W-1:0]    next_receive_out;

    // tracker state, updated on every accepted request
    logic [SEQ_W-1:0]    snd_next;
    logic [ACK_W-1:0]    rcv_next;
    logic [WIN_W-1:0]    win_last;
    logic [STAMP_W-1:0]  stamp_newest;
    logic [4:0]          conn_state;

    seg_verdict_t        expected_verdicts[$];
    int                  mismatches;
    int                  quiet_cycles;
    int                  burst_left;
    bit                  sender_idles;
    bit                  hold_request;

    tcp_segment_tracker_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .seq_number       (seq_number),
        .ack_number       (ack_number),
        .header_words     (header_words),
        .segment_bytes    (segment_bytes),
        .flag_byte        (flag_byte),
        .window_size      (window_size),
        .stamp_present    (stamp_present),
        .stamp_value      (stamp_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bad_segment      (bad_segment),
        .has_payload      (has_payload),
        .retransmitted    (retransmitted),
        .window_grew      (window_grew),
        .ack_advanced     (ack_advanced),
        .duplicate_ack    (duplicate_ack),
        .stale_ack        (stale_ack),
        .end_sequence     (end_sequence),
        .next_send_out    (next_send_out),
        .next_receive_out (next_receive_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // a lies before b modulo 2^32
    function automatic bit wraps_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] gap;
        gap = a - b;
        return gap[31];
    endfunction

    function automatic seg_verdict_t track_segment(input seg_hdr_t h);
        seg_verdict_t v;
        logic [16:0]  hb;
        logic [16:0]  seq_span;
        logic [15:0]  data_len;
        logic [4:0]   seg_bits;
        logic [4:0]   prior;
        logic         was_valid;
        v = '0;
        v.end_seq = h.seq;
        hb = {11'b0, h.hwords, 2'b00};
        was_valid = conn_state[CONN_VALID];
        if ({1'b0, h.seg_len} < hb || (h.flags[FLAG_FIN] && h.flags[FLAG_SYN]))
        begin
            v.cls.bad_segment = 1'b1;
        end
        else
        begin
            data_len = h.seg_len - hb[15:0];
            seq_span = {1'b0, data_len} + 17'(h.flags[FLAG_FIN]) + 17'(h.flags[FLAG_SYN]);
            seg_bits = '0;
            seg_bits[CONN_FIN] = h.flags[FLAG_FIN];
            seg_bits[CONN_SYN] = h.flags[FLAG_SYN];
            seg_bits[CONN_ACK] = h.flags[FLAG_ACK];
            v.end_seq = h.seq + 32'(seq_span);
            v.cls.has_payload = (data_len != 0);
            if (!h.flags[FLAG_RST] && was_valid)
            begin
                if (seq_span != 0 && (wraps_before(v.end_seq, snd_next) ||
                    (v.end_seq == snd_next && wraps_before(h.seq, snd_next))))
                    v.cls.retransmitted = 1'b1;
                if (h.win > win_last)
                    v.cls.window_grew = 1'b1;
                if (h.flags[FLAG_ACK] && wraps_before(rcv_next, h.ack))
                    v.cls.ack_advanced = 1'b1;
                if (!v.cls.ack_advanced && h.flags[FLAG_ACK] && seq_span == 0)
                begin
                    if (h.ack == rcv_next)
                    begin
                        v.cls.duplicate_ack = 1'b1;
                    end
                    else
                    begin
                        v.cls.stale_ack = 1'b1;
                        v.cls.window_grew = 1'b0;
                    end
                end
            end
            // first segment loads next-receive even without ACK
            if (v.cls.ack_advanced || !was_valid)
                rcv_next = h.ack;
            if (!v.cls.stale_ack)
                win_last = h.win;
            if (h.stamp_on)
            begin
                if (conn_state[CONN_STAMP])
                begin
                    if (wraps_before(stamp_newest, h.stamp))
                        stamp_newest = h.stamp;
                end
                else
                begin
                    stamp_newest = h.stamp;
                    conn_state[CONN_STAMP] = 1'b1;
                end
            end
            if (!v.cls.retransmitted)
            begin
                prior = conn_state;
                conn_state = seg_bits;
                conn_state[CONN_VALID] = 1'b1;
                // fin stays set across zero-length segments
                if (prior[CONN_FIN] && seq_span == 0)
                    conn_state[CONN_FIN] = 1'b1;
                if (prior[CONN_STAMP])
                    conn_state[CONN_STAMP] = 1'b1;
                if (seq_span != 0)
                    snd_next = v.end_seq;
            end
        end
        v.nxt_send = snd_next;
        v.nxt_recv = rcv_next;
        return v;
    endfunction

    function automatic seg_hdr_t mk_seg(input logic [31:0] seq, input logic [31:0] ack,
                                        input logic [3:0] hw, input logic [15:0] len,
                                        input logic [7:0] flags, input logic [15:0] win,
                                        input logic stamp_on, input logic [31:0] stamp);
        seg_hdr_t h;
        h.seq = seq;
        h.ack = ack;
        h.hwords = hw;
        h.seg_len = len;
        h.flags = flags;
        h.win = win;
        h.stamp_on = stamp_on;
        h.stamp = stamp;
        return h;
    endfunction

    function automatic seg_hdr_t random_segment();
        seg_hdr_t    h;
        int          pick;
        logic [15:0] hb;
        h.hwords = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(5, 15));
        hb = {10'b0, h.hwords, 2'b00};
        h.seq = snd_next;
        h.ack = rcv_next;
        h.seg_len = hb;
        h.flags = F_ACK | ($urandom_range(0, 1) ? F_PSH : 8'h00);
        h.win = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                            : win_last + 16'($urandom_range(0, 200)) - 16'd100;
        h.stamp_on = 1'($urandom_range(0, 1));
        h.stamp = ($urandom_range(0, 3) == 0) ? $urandom
                                              : stamp_newest + $urandom_range(0, 2000) - 32'd1000;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            // in-order data, mostly small, now and then up to the largest length
            if ($urandom_range(0, 19) == 0)
                h.seg_len = hb + 16'($urandom_range(0, 65535 - hb));
            else
                h.seg_len = hb + 16'($urandom_range(1, 64));
            h.ack = rcv_next + $urandom_range(0, 3000);
        end
        else if (pick < 45)
        begin
            case ($urandom_range(0, 2))
                0:       h.ack = rcv_next;
                1:       h.ack = rcv_next + $urandom_range(1, 3000);
                default: h.ack = rcv_next - $urandom_range(1, 3000);
            endcase
        end
        else if (pick < 55)
        begin
            h.seq = snd_next - $urandom_range(1, 300);
            h.seg_len = hb + 16'($urandom_range(1, 300));
        end
        else if (pick < 62)
        begin
            h.flags = h.flags | ($urandom_range(0, 1) ? F_FIN : F_SYN);
            if ($urandom_range(0, 1))
                h.seg_len = hb + 16'($urandom_range(1, 64));
        end
        else if (pick < 67)
        begin
            h.flags = h.flags | F_RST;
            h.ack = $urandom;
        end
        else if (pick < 75)
        begin
            if ($urandom_range(0, 1) && hb != 0)
                h.seg_len = 16'($urandom_range(0, hb - 1));
            else
                h.flags = h.flags | F_FIN | F_SYN;
        end
        else if (pick < 85)
        begin
            h.win = 16'($urandom);
            h.stamp_on = 1'b1;
        end
        else
        begin
            h.seq = $urandom;
            h.ack = $urandom;
            h.hwords = 4'($urandom_range(0, 15));
            h.seg_len = 16'($urandom);
            h.flags = 8'($urandom);
            h.win = 16'($urandom);
            h.stamp_on = 1'($urandom_range(0, 1));
            h.stamp = $urandom;
        end
        return h;
    endfunction

    task automatic send_segment(input seg_hdr_t h);
        int gap;
        @(negedge clk);
        if (sender_idles && burst_left == 0)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        seq_number    = h.seq;
        ack_number    = h.ack;
        header_words  = h.hwords;
        segment_bytes = h.seg_len;
        flag_byte     = h.flags;
        window_size   = h.win;
        stamp_present = h.stamp_on;
        stamp_value   = h.stamp;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_verdicts.push_back(track_segment(h));
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic test_malformed();
        send_segment(mk_seg(32'h0000_1000, 32'h0, 4'd5, 16'd19, F_ACK, 16'd100, 1'b0, 32'h0));
        send_segment(mk_seg(32'h0000_1000, 32'h0, 4'd5, 16'd20, F_FIN | F_SYN, 16'd100,
                            1'b0, 32'h0));
        send_segment(mk_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 16'hFFFF, 8'hFF, 16'hFFFF,
                            1'b1, 32'hFFFF_FFFF));
        send_segment(mk_seg(32'h0, 32'h0, 4'd15, 16'd59, F_ACK, 16'd0, 1'b0, 32'h0));
    endtask

    task automatic test_connection_open();
        // first segment: next-receive is loaded though ACK is clear
        send_segment(mk_seg(32'hFFFF_FFF0, 32'h0000_1234, 4'd5, 16'd20, F_SYN, 16'd1000,
                            1'b1, 32'd100));
        // data wraps the sequence space
        send_segment(mk_seg(32'hFFFF_FFF1, 32'h0000_1300, 4'd5, 16'd60, F_ACK | F_PSH, 16'd2000,
                            1'b1, 32'd200));
    endtask

    task automatic test_classification();
        send_segment(mk_seg(32'hFFFF_FFF1, 32'h0000_1300, 4'd5, 16'd60, F_ACK, 16'd2000,
                            1'b0, 32'h0));
        send_segment(mk_seg(32'h19, 32'h1300, 4'd5, 16'd20, F_ACK, 16'd2000, 1'b0, 32'h0));
        // stale ack with a bigger window: window is not taken
        send_segment(mk_seg(32'h19, 32'h1200, 4'd5, 16'd20, F_ACK, 16'd5000, 1'b0, 32'h0));
        send_segment(mk_seg(32'h19, 32'h1300, 4'd5, 16'd20, F_ACK, 16'hFFFF, 1'b1,
                            32'hFFFF_FFFF));
        send_segment(mk_seg(32'h19, 32'h1400, 4'd5, 16'd20, F_ACK, 16'd0, 1'b1, 32'd50));
        send_segment(mk_seg(32'h100, 32'h0, 4'd8, 16'd42, F_PSH, 16'd10, 1'b0, 32'h0));
    endtask

    task automatic test_fin_and_reset();
        send_segment(mk_seg(32'h10A, 32'h1400, 4'd5, 16'd20, F_FIN | F_ACK, 16'd100,
                            1'b0, 32'h0));
        send_segment(mk_seg(32'h10B, 32'h1400, 4'd5, 16'd20, F_ACK, 16'd100, 1'b0, 32'h0));
        send_segment(mk_seg(32'h10B, 32'h1400, 4'd0, 16'd0, 8'h00, 16'd100, 1'b0, 32'h0));
        send_segment(mk_seg(32'h10B, 32'h0, 4'd5, 16'd20, F_RST | F_ACK, 16'd50, 1'b0, 32'h0));
        send_segment(mk_seg(32'h10B, 32'h1500, 4'd15, 16'hFFFF, 8'hF8, 16'hFFFF, 1'b1,
                            32'h7FFF_FFFF));
        send_segment(mk_seg(32'h0, 32'hFFFF_FFFF, 4'd6, 16'd24, 8'hE2, 16'd1, 1'b1, 32'h0));
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_segment(random_segment());
    endtask

    task automatic test_backpressure();
        sender_idles = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            send_segment(random_segment());
        sender_idles = 1'b1;
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 64);
                end
                span--;
                case (mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 3) == 0);
                    2:       out_stall = ($urandom_range(0, 3) != 0);
                    default: out_stall = ~out_stall;
                endcase
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        seg_verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("result with no request pending");
                mismatches++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                check_field("bad_segment", 32'(want.cls.bad_segment), 32'(bad_segment));
                check_field("has_payload", 32'(want.cls.has_payload), 32'(has_payload));
                check_field("retransmitted", 32'(want.cls.retransmitted),
                            32'(retransmitted));
                check_field("window_grew", 32'(want.cls.window_grew), 32'(window_grew));
                check_field("ack_advanced", 32'(want.cls.ack_advanced), 32'(ack_advanced));
                check_field("duplicate_ack", 32'(want.cls.duplicate_ack),
                            32'(duplicate_ack));
                check_field("stale_ack", 32'(want.cls.stale_ack), 32'(stale_ack));
                check_field("end_sequence", want.end_seq, end_sequence);
                check_field("next_send_out", want.nxt_send, next_send_out);
                check_field("next_receive_out", want.nxt_recv, next_receive_out);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        seq_number    = '0;
        ack_number    = '0;
        header_words  = '0;
        segment_bytes = '0;
        flag_byte     = '0;
        window_size   = '0;
        stamp_present = 1'b0;
        stamp_value   = '0;
        snd_next      = '0;
        rcv_next      = '0;
        win_last      = '0;
        stamp_newest  = '0;
        conn_state    = '0;
        mismatches    = 0;
        burst_left    = 0;
        sender_idles  = 1'b1;
        hold_request  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_malformed();
        test_connection_open();
        test_classification();
        test_fin_and_reset();
        test_random_traffic();
        test_backpressure();
        test_random_traffic();

        @(negedge clk);
        in_valid = 1'b0;
        wait (expected_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tst_pkg.sv
hw/rtl/tcp_segment_tracker_core.sv
dv/tb_top.sv
